// ===== design/ident_reply_parser_macros.svh =====
// Assertion macros for the ident reply parser.
// Used by the RTL files that check their own logic; needs a clock and reset in scope.
`ifndef IDENT_REPLY_PARSER_MACROS_SVH
`define IDENT_REPLY_PARSER_MACROS_SVH

// Property holds at every clock edge outside reset.
`define IRP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define IRP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== design/irp_pkg.sv =====
// Shared constants, queue entry type and character helpers for the ident reply parser.
// No dependencies.
package irp_pkg;

   localparam int MAX_USER    = 10;
   localparam int REPLY_BYTES = 512;
   localparam int KEPT_W      = $clog2(MAX_USER + 1);
   localparam int CNT_W       = $clog2(REPLY_BYTES + 1);
   localparam int USER_LEN_W  = 4;
   localparam int TAG_LEN     = 6;
   localparam int MATCH_W     = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_USER  = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_BRACK = 8'h5B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_U     = 8'h55;

   // One queue entry: what a single input byte produced.
   typedef struct packed {
      logic                  has_user;
      logic [7:0]            user_byte;
      logic                  has_final;
      logic                  ok;
      logic [USER_LEN_W-1:0] len;
   } entry_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // "USERID", one character per index.
   function automatic logic [7:0] tag_char(input logic [MATCH_W-1:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h55;
         3'd1:    ch = 8'h53;
         3'd2:    ch = 8'h45;
         3'd3:    ch = 8'h52;
         3'd4:    ch = 8'h49;
         3'd5:    ch = 8'h44;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== design/irp_front.sv =====
// Front end of the ident reply parser: takes bytes, tracks the parse phase,
// and pushes the results of each byte into the queue. Uses irp_pkg.
`include "ident_reply_parser_macros.svh"

module irp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   input  logic               q_full,
   output logic               q_push,
   output irp_pkg::entry_type q_entry
);

   typedef enum logic [6:0] {
      PH_REMOTE   = 7'b0000001,
      PH_LOCAL    = 7'b0000010,
      PH_IDFIELD  = 7'b0000100,
      PH_OSFIELD  = 7'b0001000,
      PH_USER     = 7'b0010000,
      PH_USERDONE = 7'b0100000,
      PH_REJECT   = 7'b1000000
   } phase_type;

   typedef enum logic [2:0] {
      NUM_SKIP   = 3'b001,
      NUM_DIGITS = 3'b010,
      NUM_DONE   = 3'b100
   } num_phase_type;

   typedef struct packed {
      num_phase_type phase;
      logic          nz;
   } num_res_type;

   phase_type                    phase_ff, phase_in;
   num_phase_type                num_ff, num_in;
   logic                         rnz_ff, rnz_in;
   logic                         lnz_ff, lnz_in;
   logic [irp_pkg::MATCH_W-1:0]  match_ff, match_in;
   logic                         found_ff, found_in;
   logic                         strip_ff, strip_in;
   logic [irp_pkg::KEPT_W-1:0]   kept_ff, kept_in;
   logic [irp_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                         done_ff, done_in;
   logic                         accept;
   num_res_type                  nres;
   irp_pkg::entry_type           ent;

   // atoi-style reader: reports a nonzero digit seen in the leading digit run
   function automatic num_res_type num_feed(input num_phase_type ph, input logic [7:0] c);
      num_res_type r;
      r.phase = ph;
      r.nz    = 1'b0;
      unique case (ph)
         NUM_SKIP: begin
            if (irp_pkg::is_blank(c)) begin
               r.phase = NUM_SKIP;
            end else if (c == irp_pkg::CH_PLUS || c == irp_pkg::CH_MINUS) begin
               r.phase = NUM_DIGITS;
            end else if (irp_pkg::is_digit(c)) begin
               r.phase = NUM_DIGITS;
               r.nz    = (c != irp_pkg::CH_ZERO);
            end else begin
               r.phase = NUM_DONE;
            end
         end
         NUM_DIGITS: begin
            if (irp_pkg::is_digit(c)) begin
               r.nz = (c != irp_pkg::CH_ZERO);
            end else begin
               r.phase = NUM_DONE;
            end
         end
         default: r.phase = ph;
      endcase
      return r;
   endfunction

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      phase_in = phase_ff;
      num_in   = num_ff;
      rnz_in   = rnz_ff;
      lnz_in   = lnz_ff;
      match_in = match_ff;
      found_in = found_ff;
      strip_in = strip_ff;
      kept_in  = kept_ff;
      cnt_in   = cnt_ff;
      done_in  = done_ff;
      ent      = '0;
      nres     = num_feed(num_ff, req_data_byte);

      if (!done_ff && cnt_ff < irp_pkg::CNT_W'(irp_pkg::REPLY_BYTES)) begin
         cnt_in = cnt_ff + irp_pkg::CNT_W'(1);
         if (req_data_byte == irp_pkg::CH_NUL) begin
            done_in = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_REMOTE: begin
                  if (req_data_byte == irp_pkg::CH_COLON) begin
                     phase_in = PH_REJECT;
                  end else if (req_data_byte == irp_pkg::CH_COMMA) begin
                     phase_in = PH_LOCAL;
                     num_in   = NUM_SKIP;
                  end else begin
                     num_in = nres.phase;
                     rnz_in = rnz_ff | nres.nz;
                  end
               end
               PH_LOCAL: begin
                  if (req_data_byte == irp_pkg::CH_COLON) begin
                     phase_in = PH_IDFIELD;
                  end else begin
                     num_in = nres.phase;
                     lnz_in = lnz_ff | nres.nz;
                  end
               end
               PH_IDFIELD: begin
                  if (req_data_byte == irp_pkg::CH_COLON) begin
                     phase_in = PH_OSFIELD;
                  end else if (match_ff < irp_pkg::MATCH_W'(irp_pkg::TAG_LEN) &&
                               req_data_byte == irp_pkg::tag_char(match_ff)) begin
                     if (match_ff == irp_pkg::MATCH_W'(irp_pkg::TAG_LEN - 1)) begin
                        found_in = 1'b1;
                        match_in = '0;
                     end else begin
                        match_in = match_ff + irp_pkg::MATCH_W'(1);
                     end
                  end else begin
                     match_in = (req_data_byte == irp_pkg::CH_U) ?
                                irp_pkg::MATCH_W'(1) : '0;
                  end
               end
               PH_OSFIELD: begin
                  if (req_data_byte == irp_pkg::CH_COLON) begin
                     phase_in = (rnz_ff && lnz_ff && found_ff) ? PH_USER : PH_REJECT;
                  end
               end
               PH_USER: begin
                  if (!(strip_ff && (req_data_byte == irp_pkg::CH_TILDE ||
                                     req_data_byte == irp_pkg::CH_CARET))) begin
                     strip_in = 1'b0;
                     if (kept_ff < irp_pkg::KEPT_W'(irp_pkg::MAX_USER)) begin
                        if (req_data_byte == irp_pkg::CH_AT) begin
                           phase_in = PH_USERDONE;
                        end else if (!irp_pkg::is_blank(req_data_byte) &&
                                     req_data_byte != irp_pkg::CH_COLON &&
                                     req_data_byte != irp_pkg::CH_BRACK) begin
                           kept_in       = kept_ff + irp_pkg::KEPT_W'(1);
                           ent.has_user  = 1'b1;
                           ent.user_byte = req_data_byte;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
      end

      if (req_last_byte) begin
         ent.has_final = 1'b1;
         ent.ok        = (phase_in == PH_USER) || (phase_in == PH_USERDONE);
         ent.len       = irp_pkg::USER_LEN_W'(kept_in);
         // back to the reset state for the next reply
         phase_in = PH_REMOTE;
         num_in   = NUM_SKIP;
         rnz_in   = 1'b0;
         lnz_in   = 1'b0;
         match_in = '0;
         found_in = 1'b0;
         strip_in = 1'b1;
         kept_in  = '0;
         cnt_in   = '0;
         done_in  = 1'b0;
      end
   end

   assign q_push  = accept && (ent.has_user || ent.has_final);
   assign q_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_REMOTE;
         num_ff   <= NUM_SKIP;
         rnz_ff   <= 1'b0;
         lnz_ff   <= 1'b0;
         match_ff <= '0;
         found_ff <= 1'b0;
         strip_ff <= 1'b1;
         kept_ff  <= '0;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         num_ff   <= num_in;
         rnz_ff   <= rnz_in;
         lnz_ff   <= lnz_in;
         match_ff <= match_in;
         found_ff <= found_in;
         strip_ff <= strip_in;
         kept_ff  <= kept_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   `IRP_ASSERT(a_kept_cap, kept_ff <= irp_pkg::KEPT_W'(irp_pkg::MAX_USER), "kept count past cap")
   `IRP_ASSERT_IMPL(a_user_phase, kept_ff != '0, phase_ff == PH_USER || phase_ff == PH_USERDONE,
                    "bytes kept outside the user field")

endmodule

// ===== design/irp_queue.sv =====
// Short FIFO of per-byte result entries between front and back end.
// Uses irp_pkg.
`include "ident_reply_parser_macros.svh"

module irp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  irp_pkg::entry_type push_entry,
   input  logic               pop,
   output irp_pkg::entry_type head,
   output logic               not_empty,
   output logic               full
);

   irp_pkg::entry_type         mem [irp_pkg::QUEUE_DEPTH];
   logic [irp_pkg::QPTR_W-1:0] wr_ff, wr_in;
   logic [irp_pkg::QPTR_W-1:0] rd_ff, rd_in;
   logic [irp_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == irp_pkg::QCNT_W'(irp_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + irp_pkg::QPTR_W'(1) : wr_ff;
      rd_in    = pop ? rd_ff + irp_pkg::QPTR_W'(1) : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + irp_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - irp_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_entry;
      end
   end

   `IRP_ASSERT(a_no_overflow, !(push && full), "push into full queue")
   `IRP_ASSERT(a_no_underflow, !(pop && !not_empty), "pop from empty queue")

endmodule

// ===== design/irp_back.sv =====
// Back end of the ident reply parser: drains queue entries into result items; an entry
// that holds both gives a username item first, then the status item. Uses irp_pkg.
`include "ident_reply_parser_macros.svh"

module irp_back (
   input  logic                           clock,
   input  logic                           reset,
   input  irp_pkg::entry_type             head,
   input  logic                           not_empty,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_kind,
   output logic [7:0]                     rsp_user_byte,
   output logic                           rsp_valid_res,
   output logic [irp_pkg::USER_LEN_W-1:0] rsp_user_length,
   output logic                           rsp_last
);

   logic                          valid_ff, valid_in;
   logic                          sub_ff, sub_in;   // username part of head already sent
   logic                          load;
   logic                          send_user;
   logic                          kind_ff, kind_in;
   logic [7:0]                    byte_ff, byte_in;
   logic                          res_ff, res_in;
   logic [irp_pkg::USER_LEN_W-1:0] len_ff, len_in;
   logic                          last_ff, last_in;

   assign load      = not_empty && (!valid_ff || !rsp_stall);
   assign send_user = head.has_user && !sub_ff;

   always_comb begin
      valid_in = valid_ff;
      sub_in   = sub_ff;
      pop      = 1'b0;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      res_in   = res_ff;
      len_in   = len_ff;
      last_in  = last_ff;
      if (!valid_ff || !rsp_stall) begin
         valid_in = not_empty;
      end
      if (load) begin
         if (send_user) begin
            kind_in = irp_pkg::KIND_USER;
            byte_in = head.user_byte;
            res_in  = 1'b0;
            len_in  = '0;
            last_in = 1'b0;
            if (head.has_final) begin
               sub_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            kind_in = irp_pkg::KIND_FINAL;
            byte_in = '0;
            res_in  = head.ok;
            len_in  = head.len;
            last_in = 1'b1;
            sub_in  = 1'b0;
            pop     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      res_ff  <= res_in;
      len_ff  <= len_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_user_byte   = byte_ff;
   assign rsp_valid_res   = res_ff;
   assign rsp_user_length = len_ff;
   assign rsp_last        = last_ff;

   `IRP_ASSERT_IMPL(a_user_item_clean, valid_ff && kind_ff == irp_pkg::KIND_USER,
                    !res_ff && len_ff == '0 && !last_ff, "username item carries status")
   `IRP_ASSERT_IMPL(a_split_pending, sub_ff, not_empty && head.has_final,
                    "split entry lost its status part")

endmodule

// ===== design/ident_reply_parser.sv =====
// Top level of the ident reply parser: front end, result queue and back end.
// Uses irp_pkg, irp_front, irp_queue and irp_back.
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  req_data_byte[7:0], req_last_byte
//   rsp      out  rsp_valid / rsp_stall  rsp_kind, rsp_user_byte[7:0], rsp_valid_res,
//                                        rsp_user_length[3:0], rsp_last
//
// One byte is accepted per cycle while req_stall is low; results go through the queue
// and the output register. A byte with both items gives two rsp items, username first.
// req_stall rises only when the four-entry result queue is full.
// Synchronous reset clears the parse state, the queue and the output valid flag.
module ident_reply_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_last_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_kind,
   output logic [7:0]                     rsp_user_byte,
   output logic                           rsp_valid_res,
   output logic [irp_pkg::USER_LEN_W-1:0] rsp_user_length,
   output logic                           rsp_last
);

   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_not_empty;
   irp_pkg::entry_type q_entry;
   irp_pkg::entry_type q_head;

   irp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   irp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   irp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (q_head),
      .not_empty       (q_not_empty),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_user_byte   (rsp_user_byte),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_user_length (rsp_user_length),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== tb/sv/ident_reply_parser_tb.sv =====
// Self-checking testbench for ident_reply_parser: directed table, then random replies.
// Depends on irp_pkg and the ident_reply_parser RTL; expected items come from a local parser.
`timescale 1ns / 1ps

module ident_reply_parser_tb;
   import irp_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_BYTES = 710;
   localparam int LONG_HOLD = 400;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [47:0] ID_TAG = "USERID";

   typedef enum logic [2:0] {
      IN_REMOTE, IN_LOCAL, IN_ID_FIELD, IN_OS_FIELD, IN_USER, USER_ENDED, REJECTED
   } parse_field_e;

   typedef enum logic [1:0] {NUM_LEAD, NUM_DIGITS, NUM_OVER} num_state_e;

   typedef struct packed {
      logic                  kind;
      logic [7:0]            user_byte;
      logic                  ok;
      logic [USER_LEN_W-1:0] len;
      logic                  last;
   } reply_result_t;

   // typed rows carry a hand-written final status instead of the predicted one
   typedef struct packed {
      logic [7:0]            data;
      logic                  fin;
      logic                  typed;
      logic                  ok;
      logic [USER_LEN_W-1:0] len;
   } stim_row;

   localparam int N_DIRECTED = 21;
   localparam stim_row DIRECTED [N_DIRECTED] = '{
      '{CH_NUL,   1'b1, 1'b1, 1'b0, 4'd0},   // zero byte alone
      '{8'hFF,    1'b1, 1'b1, 1'b0, 4'd0},
      '{CH_COLON, 1'b1, 1'b1, 1'b0, 4'd0},   // colon before any comma
      '{CH_TAB,   1'b0, 1'b0, 1'b0, 4'd0},
      '{"9",      1'b0, 1'b0, 1'b0, 4'd0},
      '{CH_COMMA, 1'b0, 1'b0, 1'b0, 4'd0},
      '{"7",      1'b0, 1'b0, 1'b0, 4'd0},
      '{CH_COLON, 1'b0, 1'b0, 1'b0, 4'd0},
      '{"U",      1'b0, 1'b0, 1'b0, 4'd0},
      '{"S",      1'b0, 1'b0, 1'b0, 4'd0},
      '{"E",      1'b0, 1'b0, 1'b0, 4'd0},
      '{"R",      1'b0, 1'b0, 1'b0, 4'd0},
      '{"I",      1'b0, 1'b0, 1'b0, 4'd0},
      '{"D",      1'b0, 1'b0, 1'b0, 4'd0},
      '{CH_COLON, 1'b0, 1'b0, 1'b0, 4'd0},
      '{CH_COLON, 1'b0, 1'b0, 1'b0, 4'd0},
      '{CH_TILDE, 1'b0, 1'b0, 1'b0, 4'd0},
      '{CH_CARET, 1'b0, 1'b0, 1'b0, 4'd0},
      '{CH_BRACK, 1'b0, 1'b0, 1'b0, 4'd0},
      '{"A",      1'b0, 1'b0, 1'b0, 4'd0},
      '{CH_AT,    1'b1, 1'b1, 1'b1, 4'd1}    // '@' ends a one-byte name
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_data_byte;
   logic                  req_last_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_kind;
   logic [7:0]            rsp_user_byte;
   logic                  rsp_valid_res;
   logic [USER_LEN_W-1:0] rsp_user_length;
   logic                  rsp_last;

   // local copy of the parse state
   parse_field_e          field;
   num_state_e            num_state;
   logic                  remote_nz;
   logic                  local_nz;
   int                    match_pos;
   logic                  id_seen;
   logic                  strip_lead;
   logic [USER_LEN_W-1:0] kept;
   int                    bytes_seen;
   logic                  text_done;

   reply_result_t         queued_results[$];
   logic [7:0]            reply_text[$];

   logic quiet;
   logic hold_start;
   logic hold_done;
   int   fail_count;
   int   cycle_count;
   int   replies_sent;
   int   bytes_sent;
   int   user_checked;
   int   status_checked;
   int   input_stall_cycles;

   ident_reply_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_user_byte   (rsp_user_byte),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_user_length (rsp_user_length),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------- parser prediction ----------------

   function automatic logic is_space_char(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic reply_result_t make_result(input logic kind, input logic [7:0] ub,
                                                 input logic ok, input logic [3:0] len,
                                                 input logic last);
      reply_result_t r;
      r.kind = kind;
      r.user_byte = ub;
      r.ok = ok;
      r.len = len;
      r.last = last;
      return r;
   endfunction

   task automatic clear_parse();
      field = IN_REMOTE;
      num_state = NUM_LEAD;
      remote_nz = 1'b0;
      local_nz = 1'b0;
      match_pos = 0;
      id_seen = 1'b0;
      strip_lead = 1'b1;
      kept = '0;
      bytes_seen = 0;
      text_done = 1'b0;
   endtask

   // atoi-style scan: 1 when a nonzero digit is read
   function automatic logic number_step(input logic [7:0] c);
      logic digit;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      case (num_state)
         NUM_LEAD: begin
            if (is_space_char(c)) return 1'b0;
            if (c == CH_PLUS || c == CH_MINUS) begin
               num_state = NUM_DIGITS;
               return 1'b0;
            end
            num_state = digit ? NUM_DIGITS : NUM_OVER;
            return digit && (c != CH_ZERO);
         end
         NUM_DIGITS: begin
            if (digit) return c != CH_ZERO;
            num_state = NUM_OVER;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   task automatic parse_byte(input logic [7:0] c, input logic fin, output logic got_user,
                             output reply_result_t user_res, output reply_result_t fin_res);
      got_user = 1'b0;
      user_res = '0;
      fin_res = '0;
      if (!text_done && bytes_seen < REPLY_BYTES) begin
         bytes_seen++;
         if (c == CH_NUL) begin
            text_done = 1'b1;
         end else begin
            case (field)
               IN_REMOTE: begin
                  if (c == CH_COLON) begin
                     field = REJECTED;
                  end else if (c == CH_COMMA) begin
                     field = IN_LOCAL;
                     num_state = NUM_LEAD;
                  end else if (number_step(c)) begin
                     remote_nz = 1'b1;
                  end
               end
               IN_LOCAL: begin
                  if (c == CH_COLON) field = IN_ID_FIELD;
                  else if (number_step(c)) local_nz = 1'b1;
               end
               IN_ID_FIELD: begin
                  if (c == CH_COLON) begin
                     field = IN_OS_FIELD;
                  end else if (match_pos < 6 && c == ID_TAG[8*(5-match_pos) +: 8]) begin
                     match_pos++;
                     if (match_pos == 6) begin
                        id_seen = 1'b1;
                        match_pos = 0;
                     end
                  end else begin
                     match_pos = (c == CH_U) ? 1 : 0;
                  end
               end
               IN_OS_FIELD: begin
                  if (c == CH_COLON)
                     field = (remote_nz && local_nz && id_seen) ? IN_USER : REJECTED;
               end
               IN_USER: begin
                  if (!(strip_lead && (c == CH_TILDE || c == CH_CARET))) begin
                     strip_lead = 1'b0;
                     // past the cap, even '@' is ignored
                     if (kept < MAX_USER) begin
                        if (c == CH_AT) begin
                           field = USER_ENDED;
                        end else if (!is_space_char(c) && c != CH_COLON && c != CH_BRACK) begin
                           kept++;
                           got_user = 1'b1;
                           user_res = make_result(KIND_USER, c, 1'b0, 4'd0, 1'b0);
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
      end
      if (fin) begin
         fin_res = make_result(KIND_FINAL, 8'h00, field == IN_USER || field == USER_ENDED,
                               kept, 1'b1);
         clear_parse();
      end
   endtask

   // ---------------- stimulus helpers ----------------

   function automatic logic [7:0] space_char();
      int unsigned w;
      w = $urandom_range(8, 13);
      return (w == 8) ? CH_SPACE : 8'(w);
   endfunction

   function automatic logic [7:0] special_char();
      case ($urandom_range(0, 7))
         0:       return CH_COLON;
         1:       return CH_COMMA;
         2:       return CH_TILDE;
         3:       return CH_CARET;
         4:       return CH_AT;
         5:       return CH_BRACK;
         6:       return CH_PLUS;
         default: return CH_MINUS;
      endcase
   endfunction

   function automatic logic [7:0] noise_char();
      case ($urandom_range(0, 7))
         0:       return 8'($urandom_range(0, 255));
         1:       return 8'($urandom_range(48, 57));
         2:       return space_char();
         3, 4:    return special_char();
         5:       return ID_TAG[8*$urandom_range(0, 5) +: 8];
         default: return 8'($urandom_range(65, 90));
      endcase
   endfunction

   // anything that does not end a field or the text
   function automatic logic [7:0] field_char();
      logic [7:0] c;
      c = noise_char();
      return (c == CH_COLON || c == CH_NUL) ? "x" : c;
   endfunction

   function automatic logic [7:0] user_char();
      case ($urandom_range(0, 11))
         0:       return space_char();
         1, 2:    return special_char();
         3:       return 8'($urandom_range(1, 255));
         4:       return 8'($urandom_range(48, 57));
         default: return 8'($urandom_range(97, 122));
      endcase
   endfunction

   task automatic add_number();
      int n;
      repeat ($urandom_range(0, 2)) reply_text.push_back(space_char());
      if ($urandom_range(0, 3) == 0)
         reply_text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      // now and then a digit string far too long for an int
      n = ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(0, 3);
      repeat (n)
         reply_text.push_back(($urandom_range(0, 2) == 0) ? CH_ZERO : 8'($urandom_range(48, 57)));
      if ($urandom_range(0, 4) == 0) reply_text.push_back(noise_char());
      repeat ($urandom_range(0, 1)) reply_text.push_back(space_char());
   endtask

   // "rport , lport : USERID : os : user", with occasional damage
   task automatic build_reply(input int os_len);
      int k;
      add_number();
      if ($urandom_range(0, 11) != 0) reply_text.push_back(CH_COMMA);
      add_number();
      if ($urandom_range(0, 11) != 0) reply_text.push_back(CH_COLON);
      repeat ($urandom_range(0, 3)) reply_text.push_back(field_char());
      case ($urandom_range(0, 9))
         0: for (k = 0; k < 5; k++) reply_text.push_back(ID_TAG[8*(5-k) +: 8]);
         1: for (k = 0; k < 6; k++) reply_text.push_back(k == 2 ? "x" : ID_TAG[8*(5-k) +: 8]);
         default: for (k = 0; k < 6; k++) reply_text.push_back(ID_TAG[8*(5-k) +: 8]);
      endcase
      repeat ($urandom_range(0, 2)) reply_text.push_back(field_char());
      reply_text.push_back(CH_COLON);
      repeat (os_len) reply_text.push_back(field_char());
      if ($urandom_range(0, 11) != 0) reply_text.push_back(CH_COLON);
      repeat ($urandom_range(0, 2))
         reply_text.push_back($urandom_range(0, 1) ? CH_TILDE : CH_CARET);
      repeat ($urandom_range(0, 14)) reply_text.push_back(user_char());
      if ($urandom_range(0, 7) == 0) begin
         reply_text.push_back(CH_NUL);
         repeat ($urandom_range(0, 3)) reply_text.push_back(noise_char());
      end
   endtask

   task automatic send_byte(input logic [7:0] c, input logic fin, input logic typed,
                            input logic ok, input logic [3:0] len);
      int unsigned gap;
      logic got_user;
      reply_result_t user_res;
      reply_result_t fin_res;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= c;
      req_last_byte <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_byte(c, fin, got_user, user_res, fin_res);
      if (got_user) queued_results.push_back(user_res);
      if (fin) begin
         queued_results.push_back(typed ? make_result(KIND_FINAL, 8'h00, ok, len, 1'b1)
                                        : fin_res);
         replies_sent++;
      end
      bytes_sent++;
   endtask

   task automatic send_reply();
      int i;
      for (i = 0; i < reply_text.size(); i++)
         send_byte(reply_text[i], i == reply_text.size() - 1, 1'b0, 1'b0, 4'd0);
   endtask

   // ---------------- main sequence ----------------

   initial begin : stimulus
      int i;
      int reply_idx;
      int random_bytes;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= 8'h00;
      req_last_byte <= 1'b0;
      quiet = 1'b0;
      hold_start = 1'b0;
      fail_count = 0;
      replies_sent = 0;
      bytes_sent = 0;
      clear_parse();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_DIRECTED; i++)
         send_byte(DIRECTED[i].data, DIRECTED[i].fin, DIRECTED[i].typed,
                   DIRECTED[i].ok, DIRECTED[i].len);

      reply_idx = 0;
      random_bytes = 0;
      while (random_bytes < RANDOM_BYTES) begin
         quiet = ($urandom_range(0, 3) == 0);
         reply_text.delete();
         if (reply_idx == 2) begin
            // output side holds off while single-byte replies pile up
            hold_start = 1'b1;
            quiet = 1'b1;
            repeat (16) reply_text.push_back(noise_char());
            for (i = 0; i < 16; i++) send_byte(reply_text[i], 1'b1, 1'b0, 1'b0, 4'd0);
         end else begin
            if (reply_idx == 4)
               build_reply($urandom_range(480, 520));   // can run past the byte limit
            else if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 15)) reply_text.push_back(noise_char());
            else
               build_reply($urandom_range(0, 6));
            send_reply();
         end
         random_bytes += reply_text.size();
         reply_idx++;
      end
      req_valid <= 1'b0;

      while (queued_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d bytes in %0d replies; checked %0d username items and %0d statuses",
               bytes_sent, replies_sent, user_checked, status_checked);
      $display("input held off for %0d cycles by a full result queue", input_stall_cycles);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // ---------------- result side ----------------

   initial begin : result_side
      int unsigned hold;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_start && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!reset && rsp_valid && !rsp_stall) begin
            hold = quiet ? 0 : $urandom_range(0, 14);
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      reply_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (queued_results.size() == 0) begin
            $error("rsp item with nothing expected: kind %0d byte %02h", rsp_kind, rsp_user_byte);
            fail_count++;
         end else begin
            want = queued_results.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               fail_count++;
            end
            if (rsp_user_byte !== want.user_byte) begin
               $error("user_byte: expected %02h, got %02h", want.user_byte, rsp_user_byte);
               fail_count++;
            end
            if (rsp_valid_res !== want.ok) begin
               $error("valid_res: expected %0d, got %0d", want.ok, rsp_valid_res);
               fail_count++;
            end
            if (rsp_user_length !== want.len) begin
               $error("user_length: expected %0d, got %0d", want.len, rsp_user_length);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               fail_count++;
            end
            if (want.kind == KIND_FINAL) status_checked++;
            else user_checked++;
         end
      end
   end

   initial begin
      cycle_count = 0;
      user_checked = 0;
      status_checked = 0;
      input_stall_cycles = 0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_valid && req_stall) input_stall_cycles++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule
